/* sv/lpt_pkg.sv */
// lpt_pkg: shared types and codes of the ipv6 longest prefix table
// used by lpt_cell and ipv6_longest_prefix_table_core, no dependencies
package lpt_pkg;

  // request operation codes
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  localparam logic [7:0] MAX_PREFIX = 8'd128;

  // request key, broadcast to every cell while a scan runs
  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  srv;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [7:0]  len;
  } key_t;

  // scan token, handed from cell to cell
  typedef struct packed {
    logic       active;
    logic       found;
    logic [3:0] best_srv;
    logic [7:0] best_len;
    logic       hit;
    logic       free;
  } tok_t;

  // table update issued when the token leaves the last cell
  typedef struct packed {
    logic add;
    logic del;
  } wr_t;

endpackage

/* sv/lpt_cell.sv */
// lpt_cell: one table entry plus its stage of the scan chain
// depends on lpt_pkg
module lpt_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  lpt_pkg::key_t key,
  input  lpt_pkg::wr_t  wr,
  input  lpt_pkg::tok_t tok_in,
  output lpt_pkg::tok_t tok_out
);

  logic          vld_r;
  logic [63:0]   hi_r;
  logic [63:0]   lo_r;
  logic [7:0]    len_r;
  logic [3:0]    srv_r;
  logic          hit_here_r;
  logic          free_here_r;
  lpt_pkg::tok_t tok_r;

  lpt_pkg::tok_t tok_nxt;
  logic          hit_here_nxt;
  logic          free_here_nxt;
  logic [127:0]  ent_addr;
  logic [127:0]  key_addr;
  logic [127:0]  mask;
  logic          exact;
  logic          match;
  logic          better;

  // entry compare against the broadcast key
  always_comb begin
    ent_addr = {hi_r, lo_r};
    key_addr = {key.addr_high, key.addr_low};
    // leading len_r bits set, bit 127 first
    mask     = ~({128{1'b1}} >> len_r);
    exact    = vld_r && (srv_r == key.srv) && (len_r == key.len) && (ent_addr == key_addr);
    match    = vld_r && (((ent_addr ^ key_addr) & mask) == '0);
    better   = !tok_in.found || (len_r > tok_in.best_len) ||
               ((len_r == tok_in.best_len) && (srv_r > tok_in.best_srv));
  end

  // token update: best match, exact hit, first free slot
  always_comb begin
    tok_nxt = tok_in;
    if (match && better) begin
      tok_nxt.found    = 1'b1;
      tok_nxt.best_srv = srv_r;
      tok_nxt.best_len = len_r;
    end
    if (exact) begin
      tok_nxt.hit = 1'b1;
    end
    if (!vld_r) begin
      tok_nxt.free = 1'b1;
    end
    hit_here_nxt  = exact && !tok_in.hit;
    free_here_nxt = !vld_r && !tok_in.free;
  end

  // control state: valid bit, selection flags, token
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= 1'b0;
      hit_here_r  <= 1'b0;
      free_here_r <= 1'b0;
      tok_r       <= '0;
    end else begin
      tok_r <= tok_nxt;
      if (tok_in.active) begin
        hit_here_r  <= hit_here_nxt;
        free_here_r <= free_here_nxt;
      end
      if (wr.add && free_here_r) begin
        vld_r <= 1'b1;
      end
      if (wr.del && hit_here_r) begin
        vld_r <= 1'b0;
      end
    end
  end

  // entry payload, loaded on add into this slot
  always_ff @(posedge clk) begin
    if (wr.add && free_here_r) begin
      hi_r  <= key.addr_high;
      lo_r  <= key.addr_low;
      len_r <= key.len;
      srv_r <= key.srv;
    end
  end

  assign tok_out = tok_r;

endmodule

/* sv/ipv6_longest_prefix_table_core.sv */
// ipv6_longest_prefix_table_core: ipv6 prefix table with longest prefix lookup
// request register, then one token register per table cell, then the result register
// a new request stalls until the token of the last one has walked the whole cell chain
// one request in flight; the table update lands on the edge that loads the result
// reset clears all entry valid bits at once; entry payload is not reset
// depends on lpt_pkg and lpt_cell
module ipv6_longest_prefix_table_core #(
  parameter int TABLE_ENTRIES = 64,
  parameter int SERVER_COUNT  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [3:0]  in_server_id,
  input  logic [63:0] in_addr_high,
  input  logic [63:0] in_addr_low,
  input  logic [7:0]  in_prefix_len,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_found,
  output logic [3:0]  out_match_server,
  output logic [7:0]  out_match_len
);

  localparam logic [8:0] SRV_LIMIT = 9'(SERVER_COUNT);

  logic                       busy_r;
  logic                       start_r;
  lpt_pkg::key_t              key_r;
  logic                       out_valid_r;
  logic [1:0]                 status_r;
  logic                       found_r;
  logic [3:0]                 match_srv_r;
  logic [7:0]                 match_len_r;

  lpt_pkg::tok_t              chain [TABLE_ENTRIES+1];
  logic [TABLE_ENTRIES-1:0]   act_vec;
  lpt_pkg::tok_t              last_tok;
  lpt_pkg::wr_t               wr;
  logic                       in_accept;
  logic                       done;
  logic                       srv_ok;
  logic [7:0]                 len_sat;
  logic [1:0]                 status_nxt;
  logic                       found_nxt;
  logic [3:0]                 match_srv_nxt;
  logic [7:0]                 match_len_nxt;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = busy_r || (out_valid_r && out_stall);
  assign len_sat   = (in_prefix_len > lpt_pkg::MAX_PREFIX) ? lpt_pkg::MAX_PREFIX : in_prefix_len;

  // request capture and scan launch
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      start_r <= 1'b0;
    end else begin
      start_r <= in_accept;
      if (in_accept) begin
        busy_r <= 1'b1;
      end else if (done) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      key_r.op        <= in_op;
      key_r.srv       <= in_server_id;
      key_r.addr_high <= in_addr_high;
      key_r.addr_low  <= in_addr_low;
      key_r.len       <= len_sat;
    end
  end

  // token entering the first cell
  assign chain[0] = '{active: start_r, found: 1'b0, best_srv: 4'd0, best_len: 8'd0,
                      hit: 1'b0, free: 1'b0};

  // row of table cells
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    lpt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .key     (key_r),
      .wr      (wr),
      .tok_in  (chain[g]),
      .tok_out (chain[g+1])
    );
    assign act_vec[g] = chain[g+1].active;
  end

  assign last_tok = chain[TABLE_ENTRIES];
  assign done     = last_tok.active;
  assign srv_ok   = {5'd0, key_r.srv} < SRV_LIMIT;

  // table update and result from the finished token
  always_comb begin
    wr            = '0;
    status_nxt    = lpt_pkg::ST_OK;
    found_nxt     = 1'b0;
    match_srv_nxt = 4'd0;
    match_len_nxt = 8'd0;
    case (key_r.op)
      lpt_pkg::OP_ADD: begin
        if (!srv_ok) begin
          status_nxt = lpt_pkg::ST_FULL;
        end else if (!last_tok.hit) begin
          if (last_tok.free) begin
            wr.add = done;
          end else begin
            status_nxt = lpt_pkg::ST_FULL;
          end
        end
      end
      lpt_pkg::OP_DELETE: begin
        if (srv_ok && last_tok.hit) begin
          wr.del = done;
        end else begin
          status_nxt = lpt_pkg::ST_NOT_FOUND;
        end
      end
      lpt_pkg::OP_LOOKUP: begin
        found_nxt     = last_tok.found;
        match_srv_nxt = last_tok.found ? last_tok.best_srv : 4'd0;
        match_len_nxt = last_tok.found ? last_tok.best_len : 8'd0;
      end
      default: begin
        status_nxt = lpt_pkg::ST_OK;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      status_r    <= status_nxt;
      found_r     <= found_nxt;
      match_srv_r <= match_srv_nxt;
      match_len_r <= match_len_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_found        = found_r;
  assign out_match_server = match_srv_r;
  assign out_match_len    = match_len_r;

`ifndef ASSERT_OFF
  // at most one token walks the chain
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({start_r, act_vec}))
    else $error("more than one scan token in the cell chain");

  // a token only leaves the chain for a request in flight
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> busy_r)
    else $error("scan finished with no request in flight");

  // an accepted request launches a scan
  a_launch: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (start_r && busy_r))
    else $error("accepted request did not launch a scan");

  // a finished scan always presents a result, never over a pending one
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> (!out_valid_r || !out_stall) ##1 out_valid_r)
    else $error("finished scan did not present its result");
`endif

endmodule
